// File: sv/mma_pkg.sv
// Shared types, codes and constants of the matrix multiply-accumulate block.
package mma_pkg;

  localparam int MAX_INNER_DEF = 64;
  localparam int MAX_COLS_DEF  = 16;

  localparam int VALUE_W = 32;
  localparam int ACC_W   = 48;
  localparam int PROD_W  = 64;
  localparam int FRAC_W  = 16;
  localparam int COL_W   = 4;
  localparam int ROW_W   = 6;
  localparam int CFG_W   = 7;

  localparam logic [1:0] FUNC_COEF   = 2'd0;
  localparam logic [1:0] FUNC_PRESET = 2'd1;
  localparam logic [1:0] FUNC_ELEM   = 2'd2;

  localparam logic REG_INNER_LEN = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [6:0] INNER_LEN_RST = 7'd64;
  localparam logic [4:0] COL_COUNT_RST = 5'd16;

  typedef struct packed {
    logic coef_wr;
    logic acc_preset;
    logic elem_load;
    logic mac_issue;
    logic out_issue;
    logic out_load;
    logic acc_clr;
    logic col_clr;
  } cmd_t;

  typedef struct packed {
    logic item_coef;
    logic item_preset;
    logic item_elem;
    logic item_last;
    logic nc_zero;
    logic col_last;
    logic pipe_busy;
    logic out_full;
  } status_t;

endpackage

// File: sv/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/mma_ctrl.sv
// Controller state machine that sequences item handling, column passes and results.
module mma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mma_pkg::status_t    st,
  output mma_pkg::cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAC    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_OUT_RD = 3'd3;
  localparam logic [2:0] ST_OUT_LD = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       last_pend_r;
  logic       last_pend_nxt;
  logic       fire;

  assign in_ready = (state_r == ST_IDLE);
  assign fire     = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    last_pend_nxt = last_pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          if (st.item_coef) begin
            cmd.coef_wr = 1'b1;
          end else if (st.item_preset) begin
            cmd.acc_preset = 1'b1;
          end else if (st.item_elem) begin
            if (st.nc_zero) begin
              cmd.acc_clr = st.item_last;
            end else begin
              cmd.elem_load = 1'b1;
              last_pend_nxt = st.item_last;
              state_nxt     = ST_MAC;
            end
          end
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (st.col_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) begin
          if (last_pend_r) begin
            cmd.col_clr = 1'b1;
            state_nxt   = ST_OUT_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT_RD: begin
        cmd.out_issue = 1'b1;
        state_nxt     = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (!st.out_full) begin
          cmd.out_load = 1'b1;
          if (st.col_last) begin
            cmd.acc_clr = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

endmodule

// File: sv/mma_dp.sv
// Datapath with coefficient and accumulator memories, multiply-add pipeline and result register.
module mma_dp #(
  parameter int MAX_INNER = mma_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = mma_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [mma_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [1:0]                         in_func,
  input  logic [mma_pkg::ROW_W-1:0]          in_row_index,
  input  logic [mma_pkg::COL_W-1:0]          in_col_index,
  input  logic signed [mma_pkg::VALUE_W-1:0] in_value,
  input  logic                               in_last_element,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mma_pkg::ACC_W-1:0]   out_sum_value,
  output logic [mma_pkg::COL_W-1:0]          out_column,
  output logic                               out_last_result,
  input  mma_pkg::cmd_t                      cmd,
  output mma_pkg::status_t                   st
);

  localparam int DEPTH = MAX_INNER * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int VW    = mma_pkg::VALUE_W;
  localparam int AC_W  = mma_pkg::ACC_W;

  logic [6:0]              inner_len_r;
  logic [4:0]              col_count_r;
  logic [31:0]             ni_w;
  logic [31:0]             nc_w;
  logic [CNT_W-1:0]        nc;
  logic                    row_ok;
  logic                    col_ok;

  logic signed [VW-1:0]    elem_r;
  logic [AW-1:0]           base_r;
  logic [CW-1:0]           col_r;
  logic [CW-1:0]           col_s1_r;
  logic [CW-1:0]           col_s2_r;
  logic                    s1_v_r;
  logic                    s2_v_r;
  logic signed [mma_pkg::PROD_W-1:0] prod_r;
  logic signed [AC_W-1:0]  acc_s2_r;
  logic [MAX_COLS-1:0]     acc_vld_r;
  logic                    vld_rd_r;

  logic [AW-1:0]           coef_waddr;
  logic [AW-1:0]           coef_raddr;
  logic [VW-1:0]           coef_rd;
  logic                    acc_we;
  logic [CW-1:0]           acc_waddr;
  logic [AC_W-1:0]         acc_wdata;
  logic                    acc_re;
  logic [AC_W-1:0]         acc_rd;
  logic signed [AC_W-1:0]  addend;
  logic signed [AC_W:0]    sum_ext;
  logic signed [AC_W-1:0]  acc_sat;

  logic                    out_valid_r;
  logic signed [AC_W-1:0]  out_sum_r;
  logic [mma_pkg::COL_W-1:0] out_col_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_len_r <= mma_pkg::INNER_LEN_RST;
      col_count_r <= mma_pkg::COL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mma_pkg::REG_INNER_LEN: inner_len_r <= cfg_wdata;
        mma_pkg::REG_COL_COUNT: col_count_r <= cfg_wdata[4:0];
      endcase
    end
  end

  assign ni_w = (32'(inner_len_r) < 32'(MAX_INNER)) ? 32'(inner_len_r) : 32'(MAX_INNER);
  assign nc_w = (32'(col_count_r) < 32'(MAX_COLS)) ? 32'(col_count_r) : 32'(MAX_COLS);
  assign nc   = CNT_W'(nc_w);

  assign row_ok = 32'(in_row_index) < ni_w;
  assign col_ok = 32'(in_col_index) < nc_w;

  assign st.item_coef   = (in_func == mma_pkg::FUNC_COEF) && row_ok && col_ok;
  assign st.item_preset = (in_func == mma_pkg::FUNC_PRESET) && col_ok;
  assign st.item_elem   = (in_func == mma_pkg::FUNC_ELEM) && row_ok;
  assign st.item_last   = in_last_element;
  assign st.nc_zero     = (nc == '0);
  assign st.col_last    = ((CNT_W'(col_r) + CNT_W'(1)) == nc);
  assign st.pipe_busy   = s1_v_r || s2_v_r;
  assign st.out_full    = out_valid_r && !out_ready;

  assign coef_waddr = AW'(32'(in_row_index) * 32'(MAX_COLS) + 32'(in_col_index));
  assign coef_raddr = base_r + AW'(col_r);

  mma_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (cmd.coef_wr),
    .wr_addr (coef_waddr),
    .wr_data (in_value),
    .rd_en   (cmd.mac_issue),
    .rd_addr (coef_raddr),
    .rd_data (coef_rd)
  );

  assign acc_we    = cmd.acc_preset || s2_v_r;
  assign acc_waddr = s2_v_r ? col_s2_r : CW'(in_col_index);
  assign acc_wdata = s2_v_r ? acc_sat : {{(AC_W - VW){in_value[VW-1]}}, in_value};
  assign acc_re    = cmd.mac_issue || cmd.out_issue;

  mma_ram #(
    .WIDTH (AC_W),
    .DEPTH (MAX_COLS)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_we),
    .wr_addr (acc_waddr),
    .wr_data (acc_wdata),
    .rd_en   (acc_re),
    .rd_addr (col_r),
    .rd_data (acc_rd)
  );

  // The product is shifted arithmetically, which rounds toward minus infinity.
  assign addend  = prod_r[mma_pkg::PROD_W-1:mma_pkg::FRAC_W];
  assign sum_ext = {acc_s2_r[AC_W-1], acc_s2_r} + {addend[AC_W-1], addend};
  always_comb begin
    if (sum_ext[AC_W] != sum_ext[AC_W-1]) begin
      acc_sat = sum_ext[AC_W] ? {1'b1, {(AC_W - 1){1'b0}}} : {1'b0, {(AC_W - 1){1'b1}}};
    end else begin
      acc_sat = sum_ext[AC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (cmd.acc_clr) begin
      acc_vld_r <= '0;
    end else if (acc_we) begin
      acc_vld_r[acc_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.mac_issue;
      s2_v_r <= s1_v_r;
      if (cmd.elem_load || cmd.col_clr) begin
        col_r <= '0;
      end else if (cmd.mac_issue || cmd.out_load) begin
        col_r <= CW'(col_r + CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.elem_load) begin
      elem_r <= in_value;
      base_r <= AW'(32'(in_row_index) * 32'(MAX_COLS));
    end
    if (acc_re) begin
      vld_rd_r <= acc_vld_r[col_r];
    end
    if (cmd.mac_issue) begin
      col_s1_r <= col_r;
    end
    if (s1_v_r) begin
      prod_r   <= elem_r * $signed(coef_rd);
      acc_s2_r <= vld_rd_r ? $signed(acc_rd) : '0;
      col_s2_r <= col_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sum_r  <= vld_rd_r ? $signed(acc_rd) : '0;
      out_col_r  <= mma_pkg::COL_W'(col_r);
      out_last_r <= st.col_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sum_value   = out_sum_r;
  assign out_column      = out_col_r;
  assign out_last_result = out_last_r;

endmodule

// File: sv/matrix_multiply_accumulate.sv
// Top level of the row-times-matrix multiply-accumulate block.
// Input beats carry a func code: coefficient load, accumulator preset or row element.
// Coefficient loads and presets are written directly and leave the block ready for the next beat.
// A row element walks the active columns through one multiplier, one column per
// cycle, so a new row element is taken only after the walk and the pipeline have drained.
// A row element marked last then reads the accumulators back one column at a time.
// After the pipeline drains, one result beat per active column follows, each read in
// ST_OUT_RD and loaded into the result register in ST_OUT_LD; the
// final beat carries out_last_result and the accumulators are cleared.
// The result register lets the next input beat be taken while the final result
// still waits. When the receiver stalls, the column walk holds and nothing is lost.
// Configuration writes (inner_len, col_count) take effect at once; the user must make
// them only while the block is idle, as the block itself does not enforce this.
// Synchronous reset restores inner_len 64 and col_count 16 and zeroes all
// accumulators; coefficients hold no defined value until written.
module matrix_multiply_accumulate #(
  parameter int MAX_INNER = mma_pkg::MAX_INNER_DEF,
  parameter int MAX_COLS  = mma_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [mma_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_func,
  input  logic [mma_pkg::ROW_W-1:0]          in_row_index,
  input  logic [mma_pkg::COL_W-1:0]          in_col_index,
  input  logic signed [mma_pkg::VALUE_W-1:0] in_value,
  input  logic                               in_last_element,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mma_pkg::ACC_W-1:0]   out_sum_value,
  output logic [mma_pkg::COL_W-1:0]          out_column,
  output logic                               out_last_result
);

  mma_pkg::cmd_t    cmd;
  mma_pkg::status_t st;

  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mma_dp #(
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_func),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_value        (in_value),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum_value   (out_sum_value),
    .out_column      (out_column),
    .out_last_result (out_last_result),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

// File: sv/mma_chk.sv
// Port-level checker for the multiply-accumulate block and its bind.
module mma_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mma_pkg::ACC_W-1:0]   out_sum_value,
  input logic [mma_pkg::COL_W-1:0]          out_column,
  input logic                               out_last_result
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_sum_value) && $stable(out_column) && $stable(out_last_result))
    else $error("result beat changed while stalled");

  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=>
      !out_valid || (out_column == mma_pkg::COL_W'($past(out_column) + 1'b1)))
    else $error("result columns out of order");

endmodule

bind matrix_multiply_accumulate mma_chk u_mma_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_sum_value   (out_sum_value),
  .out_column      (out_column),
  .out_last_result (out_last_result)
);
